[hw/rtl/tct_pkg.sv]
// Shared types and item codes for the transport clock tracker.
package tct_pkg;

	localparam logic [2:0] KIND_TICK     = 3'd0;
	localparam logic [2:0] KIND_EXTERNAL = 3'd1;
	localparam logic [2:0] KIND_PLAY     = 3'd2;
	localparam logic [2:0] KIND_PAUSE    = 3'd3;
	localparam logic [2:0] KIND_RESET    = 3'd4;

	localparam int RAW_COUNT_W = 32;
	localparam int TIME_W      = 63;
	localparam int TRANSPORT_W = 64;
	localparam int OFFSET_W    = 48;

	typedef struct packed {
		logic [2:0]             kind;
		logic [RAW_COUNT_W-1:0] raw_count;
		logic [TIME_W-1:0]      external_time;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0]             boot_time;
		logic signed [TRANSPORT_W-1:0] transport_now;
		logic signed [TRANSPORT_W-1:0] transport_before;
		logic                          is_playing;
	} result_t;

endpackage

[hw/rtl/tct_item_if.sv]
// Input item channel: valid/ready plus item fields.
interface tct_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] raw_count;
	logic [62:0] external_time;

	modport source (output valid, kind, raw_count, external_time, input ready);
	modport sink (input valid, kind, raw_count, external_time, output ready);
endinterface

[hw/rtl/tct_result_if.sv]
// Result channel: valid/ready plus result fields.
interface tct_result_if;
	logic               valid;
	logic               ready;
	logic [62:0]        boot_time;
	logic signed [63:0] transport_now;
	logic signed [63:0] transport_before;
	logic               is_playing;

	modport source (output valid, boot_time, transport_now, transport_before, is_playing,
		input ready);
	modport sink (input valid, boot_time, transport_now, transport_before, is_playing,
		output ready);
endinterface

[hw/rtl/tct_cfg_if.sv]
// Configuration write channel for the transport offset register.
interface tct_cfg_if;
	logic        valid;
	logic        ready;
	logic [47:0] transport_offset;

	modport source (output valid, transport_offset, input ready);
	modport sink (input valid, transport_offset, output ready);
endinterface

[hw/rtl/transport_clock_tracker_top.sv]
// Transport clock tracker: one item in, one result out, both times reported.
//
// Every accepted item yields exactly one result. The block takes one item per
// clock cycle unless result.ready holds it back: the item lands in an input
// register, then the clock state and the result register are updated from it
// once the result register is free. That state update (a raw-width compare, a
// wrap increment and one three-operand 64-bit add) sets the rate. The input
// side stays open while a finished result waits, as long as the input register
// is free. The offset register may only be written while no item is in flight.
module transport_clock_tracker_top #(
	parameter int RAW_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	tct_item_if.sink     item,
	tct_result_if.source result,
	tct_cfg_if.sink      cfg
);
	import tct_pkg::*;

	logic                valid_s1;
	item_t               item_s1;
	logic                rvalid_q;
	result_t             res_q;
	logic [OFFSET_W-1:0] offset_q;
	logic                advance;
	logic                fire;
	result_t             post;
	logic [63:0]         raw_wide_s1;

	assign advance    = !rvalid_q || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg.valid) begin
			offset_q <= cfg.transport_offset;
		end
	end

	// Input register: refill whenever the held beat moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.kind          <= item.kind;
			item_s1.raw_count     <= item.raw_count;
			item_s1.external_time <= item.external_time;
		end
	end

	tct_core #(
		.RAW_WIDTH(RAW_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.offset (offset_q),
		.post   (post)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else if (advance) begin
			rvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= post;
		end
	end

	assign result.valid            = rvalid_q;
	assign result.boot_time        = res_q.boot_time;
	assign result.transport_now    = res_q.transport_now;
	assign result.transport_before = res_q.transport_before;
	assign result.is_playing       = res_q.is_playing;

	assign raw_wide_s1 = {32'b0, item_s1.raw_count};

	a_pause_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.kind == KIND_PAUSE) |=> !result.is_playing)
		else $error("transport still playing after pause beat");

	a_reset_loads_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.kind == KIND_RESET)
		|=> result.transport_now == $signed({16'b0, $past(offset_q)}))
		else $error("transport reset did not load the offset");

	a_tick_low_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.kind == KIND_TICK)
		|=> result.boot_time[RAW_WIDTH-1:0] == $past(raw_wide_s1[RAW_WIDTH-1:0]))
		else $error("boot time low bits differ from tick reading");

	a_play_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.kind == KIND_PLAY) |=> result.is_playing)
		else $error("transport not playing after play beat");

endmodule

[hw/rtl/tct_core.sv]
// Clock state registers and the combinational update for one item.
module tct_core #(
	parameter int RAW_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  tct_pkg::item_t                      item,
	input  logic [tct_pkg::OFFSET_W-1:0]        offset,
	output tct_pkg::result_t                    post
);
	import tct_pkg::*;

	// Reset moment plus paused total, kept as one sum.
	logic [TRANSPORT_W-1:0] base_q, base_n;
	logic [TIME_W-1:0]      since_q, since_n;
	logic [TIME_W-1:0]      pmom_q, pmom_n;
	logic [RAW_WIDTH-1:0]   prev_raw_q, prev_raw_n;
	logic [31:0]            wrap_q, wrap_n;
	logic                   run_q, run_n;
	logic [TRANSPORT_W-1:0] tval_q, tval_n;
	logic [TRANSPORT_W-1:0] tprev_q, tprev_n;

	logic [63:0]            raw_wide;
	logic [RAW_WIDTH-1:0]   raw;
	logic [RAW_WIDTH+31:0]  tick_cat;
	logic [95:0]            tick_wide;
	logic [TRANSPORT_W-1:0] off_ext;

	assign raw_wide  = {32'b0, item.raw_count};
	assign raw       = raw_wide[RAW_WIDTH-1:0];
	assign off_ext   = {{(TRANSPORT_W-OFFSET_W){1'b0}}, offset};

	always_comb begin
		base_n     = base_q;
		since_n    = since_q;
		pmom_n     = pmom_q;
		prev_raw_n = prev_raw_q;
		wrap_n     = wrap_q;
		run_n      = run_q;
		tval_n     = tval_q;
		tprev_n    = tprev_q;
		tick_cat   = '0;
		tick_wide  = '0;
		case (item.kind)
			KIND_TICK: begin
				wrap_n     = wrap_q + {31'b0, (raw < prev_raw_q)};
				prev_raw_n = raw;
				tick_cat   = {wrap_n, raw};
				tick_wide  = 96'(tick_cat);
				since_n    = tick_wide[TIME_W-1:0];
				tprev_n    = tval_q;
				if (run_q) begin
					tval_n = {1'b0, since_n} - base_q + off_ext;
				end
			end
			KIND_EXTERNAL: begin
				since_n    = item.external_time;
				prev_raw_n = item.external_time[RAW_WIDTH-1:0];
				tprev_n    = tval_q;
				if (run_q) begin
					tval_n = {1'b0, since_n} - base_q + off_ext;
				end
			end
			KIND_PLAY: begin
				if (!run_q) begin
					base_n  = base_q + {1'b0, since_q} - {1'b0, pmom_q};
					run_n   = 1'b1;
					tprev_n = tval_q;
					// since - (base + since - pmom) collapses to pmom - base
					tval_n  = {1'b0, pmom_q} - base_q + off_ext;
				end
			end
			KIND_PAUSE: begin
				if (run_q) begin
					run_n   = 1'b0;
					pmom_n  = since_q;
					tprev_n = tval_q;
				end
			end
			KIND_RESET: begin
				base_n  = {1'b0, since_q};
				pmom_n  = since_q;
				tprev_n = tval_q;
				tval_n  = off_ext;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			since_q    <= '0;
			pmom_q     <= '0;
			prev_raw_q <= '0;
			wrap_q     <= '0;
			run_q      <= 1'b1;
			tval_q     <= '0;
			tprev_q    <= '0;
		end else if (fire) begin
			base_q     <= base_n;
			since_q    <= since_n;
			pmom_q     <= pmom_n;
			prev_raw_q <= prev_raw_n;
			wrap_q     <= wrap_n;
			run_q      <= run_n;
			tval_q     <= tval_n;
			tprev_q    <= tprev_n;
		end
	end

	assign post.boot_time        = since_n;
	assign post.transport_now    = tval_n;
	assign post.transport_before = tprev_n;
	assign post.is_playing       = run_n;

endmodule
